// ===== hdl/ldpm_pkg.sv =====
// Shared types, widths and saturating helpers for the lens distortion point map.
// Used by the top level; depends on nothing.

package ldpm_pkg;

    // Field widths and fixed-point shifts
    localparam int W_FIELD  = 32;
    localparam int W_CFG_IX = 3;
    localparam int W_DIFF   = 33;   // offset from the centre, Q16.16 plus sign growth
    localparam int W_SQ     = 50;   // dx*dx, dy*dy, dx*dy and r2 after the Q16 shift
    localparam int W_SUM3   = 51;   // r2 + 2*xx and r2 + 2*yy
    localparam int W_WIDE   = 64;   // every saturated intermediate
    localparam int SH_Q16   = 16;
    localparam int SH_Q24   = 24;

    // Pipeline depth from input transfer to output register
    localparam int LATENCY  = 20;

    localparam logic signed [W_WIDE-1:0] ONE_Q24 = 64'sh0000_0000_0100_0000;

    // Configuration register indexes
    localparam logic [W_CFG_IX-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [W_CFG_IX-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [W_CFG_IX-1:0] CFG_K1       = 3'd2;
    localparam logic [W_CFG_IX-1:0] CFG_K2       = 3'd3;
    localparam logic [W_CFG_IX-1:0] CFG_K3       = 3'd4;
    localparam logic [W_CFG_IX-1:0] CFG_P1       = 3'd5;
    localparam logic [W_CFG_IX-1:0] CFG_P2       = 3'd6;

    typedef struct packed {
        logic signed [W_FIELD-1:0] point_x;
        logic signed [W_FIELD-1:0] point_y;
        logic signed [W_FIELD-1:0] point_z;
        logic        [W_FIELD-1:0] sample_value;
    } t_point_in;

    typedef struct packed {
        logic signed [W_FIELD-1:0] mapped_x;
        logic signed [W_FIELD-1:0] mapped_y;
        logic signed [W_FIELD-1:0] mapped_z;
        logic        [W_FIELD-1:0] mapped_value;
    } t_point_out;

    // Add two 64-bit values, clamp to the signed 64-bit range
    function automatic logic signed [W_WIDE-1:0] sadd64(
        input logic signed [W_WIDE-1:0] a,
        input logic signed [W_WIDE-1:0] b
    );
        logic signed [W_WIDE:0] sum;
        logic signed [W_WIDE-1:0] res;
        sum = (W_WIDE+1)'(a) + (W_WIDE+1)'(b);
        if (sum[W_WIDE] != sum[W_WIDE-1]) begin
            res = sum[W_WIDE] ? {1'b1, {(W_WIDE-1){1'b0}}} : {1'b0, {(W_WIDE-1){1'b1}}};
        end else begin
            res = sum[W_WIDE-1:0];
        end
        return res;
    endfunction

    // Double with clamping
    function automatic logic signed [W_WIDE-1:0] sdbl64(input logic signed [W_WIDE-1:0] a);
        return sadd64(a, a);
    endfunction

    // Clamp a 64-bit value to a Q16.16 coordinate
    function automatic logic signed [W_FIELD-1:0] sat32(input logic signed [W_WIDE-1:0] v);
        logic [W_WIDE-W_FIELD:0] top;
        logic signed [W_FIELD-1:0] res;
        top = v[W_WIDE-1:W_FIELD-1];
        if ((&top) || (~|top)) begin
            res = v[W_FIELD-1:0];
        end else begin
            res = v[W_WIDE-1] ? {1'b1, {(W_FIELD-1){1'b0}}} : {1'b0, {(W_FIELD-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== hdl/ldpm_mul.sv =====
// Three-stage signed multiplier: 32-bit limb partial products, a carry-merge stage,
// then floor shift, clamp if WO is narrower. Depends on nothing outside this file.

module ldpm_mul #(
    parameter int WA    = 33,
    parameter int WB    = 33,
    parameter int SHIFT = 16,
    parameter int WO    = 64
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [WA-1:0] i_a,
    input  logic signed [WB-1:0] i_b,
    output logic signed [WO-1:0] o_q
);

    localparam int HA = WA - 32;
    localparam int HB = WB - 32;
    localparam int WP = WA + WB;
    localparam int WM = ((HA > HB) ? HA : HB) + 34;
    localparam int WS = WP - SHIFT;

    logic        [63:0]       r_s1_ll;
    logic signed [HB+32:0]    r_s1_lh;
    logic signed [HA+32:0]    r_s1_hl;
    logic signed [HA+HB-1:0]  r_s1_hh;
    logic        [63:0]       r_s2_ll;
    logic signed [HA+HB-1:0]  r_s2_hh;
    logic signed [WM-1:0]     r_s2_mid;
    logic signed [WO-1:0]     r_q;

    logic signed [WP-1:0]     w_full;
    logic signed [WS-1:0]     w_q;
    logic signed [WO-1:0]     n_q;

    // Stage 1: four limb products, low limbs taken as unsigned
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_ll <= 64'(i_a[31:0]) * 64'(i_b[31:0]);
            r_s1_lh <= $signed({1'b0, i_a[31:0]}) * $signed(i_b[WB-1:32]);
            r_s1_hl <= $signed(i_a[WA-1:32]) * $signed({1'b0, i_b[31:0]});
            r_s1_hh <= $signed(i_a[WA-1:32]) * $signed(i_b[WB-1:32]);
        end
    end

    // Stage 2: merge the two cross products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_ll  <= r_s1_ll;
            r_s2_hh  <= r_s1_hh;
            r_s2_mid <= WM'(r_s1_lh) + WM'(r_s1_hl);
        end
    end

    // Stage 3: full product, arithmetic shift rounds toward minus infinity
    assign w_full = $signed({r_s2_hh, r_s2_ll}) + (WP'(r_s2_mid) <<< 32);
    assign w_q    = w_full[WP-1:SHIFT];

    generate
        if (WS > WO) begin : g_sat
            logic [WS-WO:0] w_top;
            assign w_top = w_q[WS-1:WO-1];
            always_comb begin
                if ((&w_top) || (~|w_top)) begin
                    n_q = w_q[WO-1:0];
                end else if (w_q[WS-1]) begin
                    n_q = {1'b1, {(WO-1){1'b0}}};
                end else begin
                    n_q = {1'b0, {(WO-1){1'b1}}};
                end
            end
        end else begin : g_ext
            assign n_q = WO'(w_q);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== hdl/ldpm_delay.sv =====
// Enabled shift line that aligns side data with the multiplier stages.
// Depends on nothing outside this file.

module ldpm_delay #(
    parameter int W     = 64,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_tap [DEPTH];

    // Advance all taps together with the pipeline
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

// ===== hdl/lens_distortion_point_map.sv =====
// Brown-Conrady point map (k1, k2, k3, p1, p2) over Q16.16 points, top level.
// One point per cycle is accepted unless a finished result is held by a stalled sink.
// The depth is set by five dependent 3-stage multiplies (dx^2, r4, r6, k3*r6, dx*f).
// Stalls freeze the whole pipeline; no item is lost or repeated.
// Synchronous active-low reset clears the valid pipeline and all coefficients to zero.
// Depends on ldpm_pkg, ldpm_mul and ldpm_delay.

module lens_distortion_point_map (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  ldpm_pkg::t_point_in                  i_in_data,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output ldpm_pkg::t_point_out                 o_out_data,
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [ldpm_pkg::W_CFG_IX-1:0]        i_cfg_index,
    input  logic [ldpm_pkg::W_FIELD-1:0]         i_cfg_data
);

    localparam int WF   = ldpm_pkg::W_FIELD;
    localparam int WD   = ldpm_pkg::W_DIFF;
    localparam int WSQ  = ldpm_pkg::W_SQ;
    localparam int WAX  = ldpm_pkg::W_SUM3;
    localparam int WW   = ldpm_pkg::W_WIDE;
    localparam int LAT  = ldpm_pkg::LATENCY;

    // Coefficient registers
    logic signed [WF-1:0] r_cx, r_cy, r_k1, r_k2, r_k3, r_p1, r_p2;
    logic signed [WD-1:0] w_k1, w_k2, w_k3, w_p1, w_p2;

    logic                 w_adv;
    logic [LAT-1:0]       r_vld;

    // Level 1: offsets
    logic signed [WD-1:0] r_dx, r_dy;
    // Level 4: squares and cross product
    logic signed [WSQ-1:0] w_xx, w_yy, w_xy, w_xy5;
    // Level 5: radius and tangential sums
    logic signed [WSQ-1:0] r_r2, n_r2, w_r2_8;
    logic signed [WAX-1:0] r_ax, r_ay, n_ax, n_ay;
    // Level 8 products
    logic signed [WW-1:0] w_r4, w_k1r2, w_p1xy, w_p2xy, w_p2ax, w_p1ay;
    // Level 9
    logic signed [WW-1:0] r_f1, r_tx, r_ty, w_f1_11;
    // Level 11 products
    logic signed [WW-1:0] w_r6, w_k2r4;
    // Level 12
    logic signed [WW-1:0] r_f2, w_f2_14;
    // Level 14 product
    logic signed [WW-1:0] w_k3r6;
    // Level 15
    logic signed [WW-1:0] r_f3;
    logic [2*WD-1:0]      w_dxy_15;
    // Level 18 products
    logic signed [WW-1:0] w_dxf, w_dyf;
    logic [2*WW-1:0]      w_txy_18;
    // Level 19 and 20
    logic signed [WW-1:0] r_sx, r_sy;
    logic signed [WF-1:0] r_mx, r_my;
    logic [2*WF-1:0]      w_pass;

    // Write one coefficient; out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_k1 <= '0;
            r_k2 <= '0;
            r_k3 <= '0;
            r_p1 <= '0;
            r_p2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ldpm_pkg::CFG_CENTER_X: r_cx <= i_cfg_data;
                ldpm_pkg::CFG_CENTER_Y: r_cy <= i_cfg_data;
                ldpm_pkg::CFG_K1:       r_k1 <= i_cfg_data;
                ldpm_pkg::CFG_K2:       r_k2 <= i_cfg_data;
                ldpm_pkg::CFG_K3:       r_k3 <= i_cfg_data;
                ldpm_pkg::CFG_P1:       r_p1 <= i_cfg_data;
                ldpm_pkg::CFG_P2:       r_p2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_k1 = WD'(r_k1);
    assign w_k2 = WD'(r_k2);
    assign w_k3 = WD'(r_k3);
    assign w_p1 = WD'(r_p1);
    assign w_p2 = WD'(r_p2);

    // Whole pipeline advances unless a finished result is held by the sink
    assign w_adv       = !r_vld[LAT-1] || !i_out_stall;
    assign o_in_stall  = !w_adv;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // Level 1: offset the point from the centre
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dx <= WD'(i_in_data.point_x) - WD'(r_cx);
            r_dy <= WD'(i_in_data.point_y) - WD'(r_cy);
        end
    end

    // Levels 2..4: squares and cross product in Q34.16
    ldpm_mul #(.WA(WD), .WB(WD), .SHIFT(ldpm_pkg::SH_Q16), .WO(WSQ)) u_mul_xx (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r_dx), .i_b(r_dx), .o_q(w_xx));
    ldpm_mul #(.WA(WD), .WB(WD), .SHIFT(ldpm_pkg::SH_Q16), .WO(WSQ)) u_mul_yy (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r_dy), .i_b(r_dy), .o_q(w_yy));
    ldpm_mul #(.WA(WD), .WB(WD), .SHIFT(ldpm_pkg::SH_Q16), .WO(WSQ)) u_mul_xy (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r_dx), .i_b(r_dy), .o_q(w_xy));

    // Level 5: r2 and the tangential radius sums (non-negative, no clamp needed)
    always_comb begin
        n_r2 = w_xx + w_yy;
        n_ax = WAX'(n_r2) + (WAX'(w_xx) <<< 1);
        n_ay = WAX'(n_r2) + (WAX'(w_yy) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_r2 <= n_r2;
            r_ax <= n_ax;
            r_ay <= n_ay;
        end
    end

    ldpm_delay #(.W(WSQ), .DEPTH(1)) u_dly_xy (
        .i_clk(i_clk), .i_en(w_adv), .i_d(w_xy), .o_q(w_xy5));

    // Levels 6..8: r4, radial k1 term and tangential products
    ldpm_mul #(.WA(WSQ), .WB(WSQ), .SHIFT(ldpm_pkg::SH_Q16), .WO(WW)) u_mul_r4 (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r_r2), .i_b(r_r2), .o_q(w_r4));
    ldpm_mul #(.WA(WD), .WB(WSQ), .SHIFT(ldpm_pkg::SH_Q16), .WO(WW)) u_mul_k1 (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_k1), .i_b(r_r2), .o_q(w_k1r2));
    ldpm_mul #(.WA(WD), .WB(WSQ), .SHIFT(ldpm_pkg::SH_Q24), .WO(WW)) u_mul_p1xy (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_p1), .i_b(w_xy5), .o_q(w_p1xy));
    ldpm_mul #(.WA(WD), .WB(WSQ), .SHIFT(ldpm_pkg::SH_Q24), .WO(WW)) u_mul_p2xy (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_p2), .i_b(w_xy5), .o_q(w_p2xy));
    ldpm_mul #(.WA(WD), .WB(WAX), .SHIFT(ldpm_pkg::SH_Q24), .WO(WW)) u_mul_p2ax (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_p2), .i_b(r_ax), .o_q(w_p2ax));
    ldpm_mul #(.WA(WD), .WB(WAX), .SHIFT(ldpm_pkg::SH_Q24), .WO(WW)) u_mul_p1ay (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_p1), .i_b(r_ay), .o_q(w_p1ay));

    ldpm_delay #(.W(WSQ), .DEPTH(3)) u_dly_r2 (
        .i_clk(i_clk), .i_en(w_adv), .i_d(r_r2), .o_q(w_r2_8));

    // Level 9: first radial sum and both tangential offsets
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1 <= ldpm_pkg::sadd64(ldpm_pkg::ONE_Q24, w_k1r2);
            r_tx <= ldpm_pkg::sadd64(ldpm_pkg::sdbl64(w_p1xy), w_p2ax);
            r_ty <= ldpm_pkg::sadd64(w_p1ay, ldpm_pkg::sdbl64(w_p2xy));
        end
    end

    // Levels 9..11: r6 and radial k2 term
    ldpm_mul #(.WA(WW), .WB(WSQ), .SHIFT(ldpm_pkg::SH_Q16), .WO(WW)) u_mul_r6 (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_r4), .i_b(w_r2_8), .o_q(w_r6));
    ldpm_mul #(.WA(WD), .WB(WW), .SHIFT(ldpm_pkg::SH_Q16), .WO(WW)) u_mul_k2 (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_k2), .i_b(w_r4), .o_q(w_k2r4));

    ldpm_delay #(.W(WW), .DEPTH(2)) u_dly_f1 (
        .i_clk(i_clk), .i_en(w_adv), .i_d(r_f1), .o_q(w_f1_11));

    // Level 12: add the k2 term
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f2 <= ldpm_pkg::sadd64(w_f1_11, w_k2r4);
        end
    end

    // Levels 12..14: radial k3 term
    ldpm_mul #(.WA(WD), .WB(WW), .SHIFT(ldpm_pkg::SH_Q16), .WO(WW)) u_mul_k3 (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_k3), .i_b(w_r6), .o_q(w_k3r6));

    ldpm_delay #(.W(WW), .DEPTH(2)) u_dly_f2 (
        .i_clk(i_clk), .i_en(w_adv), .i_d(r_f2), .o_q(w_f2_14));

    // Level 15: full radial factor in Q.24
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f3 <= ldpm_pkg::sadd64(w_f2_14, w_k3r6);
        end
    end

    ldpm_delay #(.W(2*WD), .DEPTH(14)) u_dly_dxy (
        .i_clk(i_clk), .i_en(w_adv), .i_d({r_dx, r_dy}), .o_q(w_dxy_15));

    // Levels 16..18: scale the offsets by the radial factor
    ldpm_mul #(.WA(WD), .WB(WW), .SHIFT(ldpm_pkg::SH_Q24), .WO(WW)) u_mul_dxf (
        .i_clk(i_clk), .i_en(w_adv), .i_a($signed(w_dxy_15[2*WD-1:WD])), .i_b(r_f3),
        .o_q(w_dxf));
    ldpm_mul #(.WA(WD), .WB(WW), .SHIFT(ldpm_pkg::SH_Q24), .WO(WW)) u_mul_dyf (
        .i_clk(i_clk), .i_en(w_adv), .i_a($signed(w_dxy_15[WD-1:0])), .i_b(r_f3),
        .o_q(w_dyf));

    ldpm_delay #(.W(2*WW), .DEPTH(9)) u_dly_txy (
        .i_clk(i_clk), .i_en(w_adv), .i_d({r_tx, r_ty}), .o_q(w_txy_18));

    // Level 19: add the tangential offsets
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sx <= ldpm_pkg::sadd64(w_dxf, $signed(w_txy_18[2*WW-1:WW]));
            r_sy <= ldpm_pkg::sadd64(w_dyf, $signed(w_txy_18[WW-1:0]));
        end
    end

    // Level 20: add the centre back and clamp to Q16.16
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mx <= ldpm_pkg::sat32(ldpm_pkg::sadd64(r_sx, WW'(r_cx)));
            r_my <= ldpm_pkg::sat32(ldpm_pkg::sadd64(r_sy, WW'(r_cy)));
        end
    end

    // Carry z and the value word alongside the arithmetic
    ldpm_delay #(.W(2*WF), .DEPTH(LAT)) u_dly_pass (
        .i_clk(i_clk), .i_en(w_adv),
        .i_d({i_in_data.point_z, i_in_data.sample_value}), .o_q(w_pass));

    always_comb begin
        o_out_data.mapped_x     = r_mx;
        o_out_data.mapped_y     = r_my;
        o_out_data.mapped_z     = w_pass[2*WF-1:WF];
        o_out_data.mapped_value = w_pass[WF-1:0];
    end

endmodule
